### hw/rtl/icmppr_pkg.sv
// Shared types, codes and constants of the ICMP probe response matcher.
package icmppr_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 1024;

  // ICMP message types
  localparam logic [7:0] TYPE_ECHO_REPLY    = 8'd0;
  localparam logic [7:0] TYPE_TIME_EXCEEDED = 8'd11;

  // result status codes
  localparam logic [1:0] ST_ACCEPTED   = 2'd0;
  localparam logic [1:0] ST_TOO_SHORT  = 2'd1;
  localparam logic [1:0] ST_OTHER_TYPE = 2'd2;
  localparam logic [1:0] ST_MISMATCH   = 2'd3;

  // reply kinds
  localparam logic KIND_ECHO          = 1'b0;
  localparam logic KIND_TIME_EXCEEDED = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SEQ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_TICK    = 2'd2;
  localparam int CFG_DATA_W = 32;

  // packet layout
  localparam int ICMP_HDR_BYTES = 8;
  localparam int FIELD_OFS      = 4;
  localparam int SRC_FIRST      = 12;
  localparam int SRC_LAST       = 15;

  // stream widths
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 1;

  typedef struct packed {
    logic [1:0]  status;
    logic        reply_kind;
    logic [31:0] source_address;
    logic [31:0] round_trip_ms;
  } icmppr_result_t;

endpackage

### hw/rtl/icmppr_parse.sv
// Per-packet byte tracker: captures header fields and forms the result on the last byte.
module icmppr_parse #(
  parameter int MAX_PACKET_BYTES = icmppr_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  logic [7:0]                  byte_value,
  input  logic                        is_last,
  input  logic [31:0]                 current_tick,
  input  logic [15:0]                 expected_id,
  input  logic [15:0]                 expected_seq,
  input  logic [31:0]                 send_tick,
  output icmppr_pkg::icmppr_result_t  result
);
  import icmppr_pkg::*;

  localparam int IDX_W = $clog2(MAX_PACKET_BYTES + 1);
  localparam int CW    = (IDX_W > 8) ? IDX_W : 8;
  localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_PACKET_BYTES);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [3:0]       ohw_r, ohw_nxt;
  logic [3:0]       ihw_r, ihw_nxt;
  logic [7:0]       mtype_r, mtype_nxt;
  logic [15:0]      id_r, id_nxt;
  logic [15:0]      seq_r, seq_nxt;
  logic [31:0]      src_r, src_nxt;
  logic [3:0]       seen_r, seen_nxt;

  logic          keep;
  logic          after_type;
  logic [CW-1:0] idx_c, o_c, p_c, q_c, need_c;
  logic          put_en;
  logic [1:0]    put_k;
  logic          short_pkt;
  logic [1:0]    status;

  always_comb begin
    keep    = idx_r < MAX_IDX;
    idx_c   = CW'(idx_r);
    ohw_nxt = (keep && idx_r == '0) ? byte_value[3:0] : ohw_r;
    o_c     = CW'({ohw_nxt, 2'b00});
    p_c     = o_c + CW'(ICMP_HDR_BYTES);
    q_c     = p_c + CW'({ihw_r, 2'b00});

    src_nxt = src_r;
    if (keep && idx_c >= CW'(SRC_FIRST) && idx_c <= CW'(SRC_LAST)) begin
      src_nxt = {src_r[23:0], byte_value};
    end
    mtype_nxt  = (keep && idx_c == o_c) ? byte_value : mtype_r;
    after_type = keep && (idx_c > o_c);

    ihw_nxt = ihw_r;
    put_en  = 1'b0;
    put_k   = 2'd0;
    if (after_type && mtype_r == TYPE_ECHO_REPLY) begin
      if (idx_c >= o_c + CW'(FIELD_OFS) && idx_c <= o_c + CW'(FIELD_OFS + 3)) begin
        put_en = 1'b1;
        put_k  = 2'(idx_c - (o_c + CW'(FIELD_OFS)));
      end
    end else if (after_type && mtype_r == TYPE_TIME_EXCEEDED) begin
      if (idx_c == p_c) begin
        ihw_nxt = byte_value[3:0];
      end
      // inner ICMP id/seq sits past the quoted IPv4 header
      if (idx_c > p_c && idx_c >= q_c + CW'(FIELD_OFS)
          && idx_c <= q_c + CW'(FIELD_OFS + 3)) begin
        put_en = 1'b1;
        put_k  = 2'(idx_c - (q_c + CW'(FIELD_OFS)));
      end
    end

    id_nxt   = id_r;
    seq_nxt  = seq_r;
    seen_nxt = seen_r;
    if (put_en) begin
      unique case (put_k)
        2'd0: id_nxt[15:8] = byte_value;
        2'd1: id_nxt[7:0]  = byte_value;
        2'd2: seq_nxt[15:8] = byte_value;
        2'd3: seq_nxt[7:0]  = byte_value;
      endcase
      seen_nxt[put_k] = 1'b1;
    end

    idx_nxt = keep ? idx_r + 1'b1 : idx_r;

    need_c    = o_c + CW'(ICMP_HDR_BYTES);
    short_pkt = CW'(idx_nxt) < need_c;
    priority if (short_pkt) begin
      status = ST_TOO_SHORT;
    end else if (mtype_nxt != TYPE_ECHO_REPLY && mtype_nxt != TYPE_TIME_EXCEEDED) begin
      status = ST_OTHER_TYPE;
    end else if (seen_nxt != 4'hF) begin
      status = ST_TOO_SHORT;
    end else if (id_nxt != expected_id || seq_nxt != expected_seq) begin
      status = ST_MISMATCH;
    end else begin
      status = ST_ACCEPTED;
    end

    result.status     = status;
    result.reply_kind = KIND_ECHO;
    if (status == ST_ACCEPTED || status == ST_MISMATCH) begin
      result.reply_kind = (mtype_nxt == TYPE_TIME_EXCEEDED) ? KIND_TIME_EXCEEDED : KIND_ECHO;
    end
    result.source_address = (status == ST_ACCEPTED) ? src_nxt : 32'd0;
    result.round_trip_ms  = (status == ST_ACCEPTED) ? current_tick - send_tick : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      ohw_r   <= '0;
      ihw_r   <= '0;
      mtype_r <= '0;
      id_r    <= '0;
      seq_r   <= '0;
      src_r   <= '0;
      seen_r  <= '0;
    end else if (step_en) begin
      if (is_last) begin
        idx_r   <= '0;
        ohw_r   <= '0;
        ihw_r   <= '0;
        mtype_r <= '0;
        id_r    <= '0;
        seq_r   <= '0;
        src_r   <= '0;
        seen_r  <= '0;
      end else begin
        idx_r   <= idx_nxt;
        ohw_r   <= ohw_nxt;
        ihw_r   <= ihw_nxt;
        mtype_r <= mtype_nxt;
        id_r    <= id_nxt;
        seq_r   <= seq_nxt;
        src_r   <= src_nxt;
        seen_r  <= seen_nxt;
      end
    end
  end

endmodule

### hw/rtl/icmp_probe_response_matcher.sv
// Top level of the ICMP probe response matcher: stream ports, config registers, pipeline.
//
// Usage:
//   in_*  : one received IPv4 packet byte per item, in wire order; in_tlast marks
//           the final byte, and the tick in in_tdata is used on that byte only.
//   out_* : one result item per packet, produced by the item carrying in_tlast:
//           status, reply kind, outer source address and round trip in ms.
//   cfg_* : expected id, expected sequence and send tick; write only while idle.
// After the last byte is accepted into the input register, its result is captured in
//   the result register once the result slot is free.
// Throughput: one byte per cycle unless a last byte waits for a busy result slot; the
//   capture logic between the input and result registers updates its packet state per byte.
// Bytes past MAX_PACKET_BYTES are consumed and ignored.
// Reset (rst_n low, synchronous) empties both stages, clears the packet state
//   and zeros the configuration registers.
// Stall: a result held by out_tready low keeps the output register; non-last
//   bytes keep flowing, and a last byte waits in the input register until the
//   result slot frees.
module icmp_probe_response_matcher #(
  parameter int MAX_PACKET_BYTES = icmppr_pkg::MAX_PACKET_BYTES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // in_tdata: byte_value [7:0], current_tick [39:8]
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [icmppr_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                  in_tlast,
  // out_tdata: status [1:0], source_address [33:2], round_trip_ms [65:34], zero [71:66]
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [icmppr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // out_tuser: reply_kind [0]
  output logic [icmppr_pkg::OUT_TUSER_W-1:0]    out_tuser,
  input  logic                                  cfg_we,
  input  logic [icmppr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [icmppr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import icmppr_pkg::*;

  // configuration registers
  logic [15:0] exp_id_r;
  logic [15:0] exp_seq_r;
  logic [31:0] send_tick_r;

  // input register
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  logic [31:0] s1_tick_r;

  // result register
  logic           out_valid_r;
  icmppr_result_t out_res_r;

  icmppr_result_t res;
  logic           advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_id_r    <= '0;
      exp_seq_r   <= '0;
      send_tick_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_EXPECTED_ID:  exp_id_r    <= cfg_wdata[15:0];
        CFG_EXPECTED_SEQ: exp_seq_r   <= cfg_wdata[15:0];
        CFG_SEND_TICK:    send_tick_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // a non-last byte never needs the result slot
  assign advance   = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r <= in_tdata[7:0];
      s1_tick_r <= in_tdata[39:8];
      s1_last_r <= in_tlast;
    end
  end

  icmppr_parse #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (advance),
    .byte_value   (s1_byte_r),
    .is_last      (s1_last_r),
    .current_tick (s1_tick_r),
    .expected_id  (exp_id_r),
    .expected_seq (exp_seq_r),
    .send_tick    (send_tick_r),
    .result       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_res_r.round_trip_ms, out_res_r.source_address,
                       out_res_r.status};
  assign out_tuser  = out_res_r.reply_kind;

endmodule

### hw/rtl/icmppr_checker.sv
// Port-level assertions for the ICMP probe response matcher, bound to the top level.
module icmppr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [0:0]  out_tuser
);
  import icmppr_pkg::*;

  // result register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // address and round trip reported only for an accepted reply
  a_zero_unless_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] != ST_ACCEPTED |-> out_tdata[65:2] == 64'd0)
    else $error("payload set on non-accepted result");

  // no reply kind for short or foreign packets, padding stays zero
  a_kind_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ST_TOO_SHORT || out_tdata[1:0] == ST_OTHER_TYPE)
    |-> out_tuser == 1'b0 && out_tdata[71:66] == 6'd0)
    else $error("reply kind set on rejected packet");

endmodule

bind icmp_probe_response_matcher icmppr_checker u_icmppr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
